>>> rtl/lzwh_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lzwh_pkg
// Shared types, constants and helpers of the hashed LZW encoder.
// -----------------------------------------------------------------------------
package lzwh_pkg;

   localparam int HASH_SLOTS_DEFAULT = 65536;
   localparam int CODE_BITS          = 16;
   localparam int NFC_BITS           = 17;
   localparam int WIDTH_BITS         = 5;
   localparam int EPOCH_BITS         = 8;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [NFC_BITS-1:0]   FIRST_FREE_CODE = 17'd256;
   localparam logic [WIDTH_BITS-1:0] WIDTH_FLOOR     = 5'd9;
   localparam logic [WIDTH_BITS-1:0] WIDTH_CEIL      = 5'd16;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_MIN_CODE_BITS = 2'd0;
   localparam logic [1:0] REG_MAX_CODE_BITS = 2'd1;
   localparam logic [1:0] REG_EARLY_RESET   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [15:0]           out_code;
      logic [WIDTH_BITS-1:0] code_width;
      logic                  dict_was_reset;
      logic                  last_code;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [15:0]           prefix;
      logic [7:0]            data_byte;
      logic [15:0]           code;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic probe_next;
      logic hit;
      logic probe_miss;
      logic miss_commit;
      logic flush;
      logic wipe_step;
   } cmd_type;

   typedef struct packed {
      logic prefix_valid;
      logic eos;
      logic entry_valid;
      logic entry_match;
      logic probe_exhausted;
      logic reset_due;
      logic epoch_last;
      logic out_free;
      logic wipe_last;
   } status_type;

   function automatic logic [WIDTH_BITS-1:0] eff_min(input logic [WIDTH_BITS-1:0] m);
      logic [WIDTH_BITS-1:0] r;
      r = m;
      if (r < WIDTH_FLOOR) r = WIDTH_FLOOR;
      if (r > WIDTH_CEIL) r = WIDTH_CEIL;
      return r;
   endfunction

   function automatic logic [WIDTH_BITS-1:0] eff_max(input logic [WIDTH_BITS-1:0] mx,
                                                     input logic [WIDTH_BITS-1:0] mn);
      logic [WIDTH_BITS-1:0] r;
      logic [WIDTH_BITS-1:0] lo;
      lo = eff_min(mn);
      r  = mx;
      if (r > WIDTH_CEIL) r = WIDTH_CEIL;
      if (r < lo) r = lo;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/lzwh_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lzwh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module lzwh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/lzwh_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lzwh_ctrl
// Sequencer of the encoder: accept, probe, emit, flush and table wipe.
// -----------------------------------------------------------------------------
module lzwh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lzwh_pkg::status_type status,
   output lzwh_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_WIPE  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_START = 6'b000100,
      S_PROBE = 6'b001000,
      S_MISS  = 6'b010000,
      S_FLUSH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_last) begin
               state_in = status.eos ? S_FLUSH : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.prefix_valid ? S_PROBE : S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (status.epoch_last) state_in = S_WIPE;
            else state_in = status.eos ? S_FLUSH : S_IDLE;
         end
         S_PROBE: begin
            if (!status.entry_valid ||
                (!status.entry_match && status.probe_exhausted)) begin
               cmd.probe_miss = 1'b1;
               state_in       = S_MISS;
            end else if (status.entry_match) begin
               cmd.hit  = 1'b1;
               state_in = status.eos ? S_FLUSH : S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         S_MISS: begin
            // hold until the result register can take the code
            if (status.out_free) begin
               cmd.miss_commit = 1'b1;
               if (status.reset_due && status.epoch_last) state_in = S_WIPE;
               else state_in = status.eos ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_wipe_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIPE) |-> !req_ready)
      else $error("request accepted during table wipe");
   a_probe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.prefix_valid) |=> (state_ff == S_PROBE))
      else $error("accepted request did not start a probe");
   a_hit_needs_match: assert property (@(posedge clock) disable iff (reset)
      cmd.hit |-> (status.entry_valid && status.entry_match))
      else $error("hit taken without a matching entry");
`endif

endmodule
`default_nettype wire

>>> rtl/lzwh_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lzwh_datapath
// Prefix and code registers, hash and probe address, dictionary RAM and the
// result register.
// -----------------------------------------------------------------------------
module lzwh_datapath #(
   parameter int HASH_SLOTS = lzwh_pkg::HASH_SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lzwh_pkg::cmd_type      cmd,
   output lzwh_pkg::status_type        status,
   input  wire lzwh_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lzwh_pkg::rsp_type           rsp_data,
   input  wire logic [4:0]             min_code_bits,
   input  wire logic [4:0]             max_code_bits,
   input  wire logic                   early_reset
);

   localparam int AW = $clog2(HASH_SLOTS);

   // slot index of a 16-bit hash value, by repeated compare and subtract
   function automatic logic [AW-1:0] slot_of(input logic [15:0] h);
      logic [23:0] r;
      logic [23:0] step;
      r = {8'd0, h};
      for (int k = 7; k >= 0; k--) begin
         step = 24'(HASH_SLOTS) << k;
         if (r >= step) r = r - step;
      end
      return r[AW-1:0];
   endfunction

   logic [15:0]                     prefix_ff;
   logic                            prefix_valid_ff;
   logic [lzwh_pkg::NFC_BITS-1:0]   nfc_ff;
   logic [lzwh_pkg::WIDTH_BITS-1:0] width_ff;
   logic [lzwh_pkg::EPOCH_BITS-1:0] epoch_ff;
   logic [7:0]                      byte_ff;
   logic                            eos_ff;
   logic [AW-1:0]                   pos_ff;
   logic [AW:0]                     probes_ff;
   logic                            slot_free_ff;
   logic [AW-1:0]                   wipe_ff;
   logic                            rsp_valid_ff;
   lzwh_pkg::rsp_type               rsp_ff;

   lzwh_pkg::entry_type             rd_entry;
   lzwh_pkg::entry_type             wr_entry;
   logic [AW-1:0]                   rd_addr;
   logic [AW-1:0]                   wr_addr;
   logic                            wr_en;
   logic [AW-1:0]                   pos_inc;
   logic [lzwh_pkg::WIDTH_BITS-1:0] maxb;
   logic [lzwh_pkg::WIDTH_BITS-1:0] minb;
   logic [lzwh_pkg::NFC_BITS-1:0]   top;
   logic [lzwh_pkg::NFC_BITS-1:0]   nfc_step;
   logic                            reset_due;
   logic                            insert_ok;

   assign minb      = lzwh_pkg::eff_min(min_code_bits);
   assign maxb      = lzwh_pkg::eff_max(max_code_bits, min_code_bits);
   assign top       = (lzwh_pkg::NFC_BITS'(1) << width_ff) - lzwh_pkg::NFC_BITS'(1);
   assign reset_due = early_reset &&
      (nfc_ff >= ((lzwh_pkg::NFC_BITS'(1) << maxb) - lzwh_pkg::NFC_BITS'(1)));
   assign insert_ok = !reset_due && (nfc_ff <= top);
   assign nfc_step  = insert_ok ? nfc_ff + lzwh_pkg::NFC_BITS'(1) : nfc_ff;
   assign pos_inc   = (pos_ff == AW'(HASH_SLOTS - 1)) ? '0 : pos_ff + AW'(1);

   // the hash of (prefix, byte) keeps only the low prefix byte above the data byte
   assign rd_addr = cmd.probe_next ? pos_inc : slot_of({prefix_ff[7:0], req_data.data_byte});

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_entry = '{epoch: epoch_ff, prefix: prefix_ff, data_byte: byte_ff,
                   code: nfc_ff[15:0]};
      if (cmd.wipe_step) begin
         wr_en    = 1'b1;
         wr_addr  = wipe_ff;
         wr_entry = '0;
      end else if (cmd.miss_commit && insert_ok && slot_free_ff) begin
         wr_en = 1'b1;
      end
   end

   lzwh_ram #(
      .WIDTH ($bits(lzwh_pkg::entry_type)),
      .DEPTH (HASH_SLOTS)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      status                 = '0;
      status.prefix_valid    = prefix_valid_ff;
      status.eos             = eos_ff;
      status.entry_valid     = (rd_entry.epoch == epoch_ff);
      status.entry_match     = (rd_entry.prefix == prefix_ff) &&
                               (rd_entry.data_byte == byte_ff);
      status.probe_exhausted = (probes_ff == (AW+1)'(HASH_SLOTS));
      status.reset_due       = reset_due;
      status.epoch_last      = (epoch_ff == '1);
      status.out_free        = !rsp_valid_ff || rsp_ready;
      status.wipe_last       = (wipe_ff == AW'(HASH_SLOTS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         nfc_ff          <= lzwh_pkg::FIRST_FREE_CODE;
         width_ff        <= lzwh_pkg::WIDTH_FLOOR;
         epoch_ff        <= '0;
         eos_ff          <= 1'b0;
         wipe_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.miss_commit || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            eos_ff <= req_data.end_of_stream;
         end
         if (cmd.wipe_step) begin
            if (status.wipe_last) begin
               wipe_ff  <= '0;
               epoch_ff <= lzwh_pkg::EPOCH_BITS'(1);
            end else begin
               wipe_ff <= wipe_ff + AW'(1);
            end
         end
         if (cmd.start) begin
            epoch_ff        <= epoch_ff + lzwh_pkg::EPOCH_BITS'(1);
            nfc_ff          <= lzwh_pkg::FIRST_FREE_CODE;
            width_ff        <= minb;
            prefix_ff       <= {8'd0, byte_ff};
            prefix_valid_ff <= 1'b1;
         end
         if (cmd.hit) begin
            prefix_ff <= rd_entry.code;
         end
         if (cmd.miss_commit) begin
            prefix_ff <= {8'd0, byte_ff};
            if (reset_due) begin
               epoch_ff <= epoch_ff + lzwh_pkg::EPOCH_BITS'(1);
               nfc_ff   <= lzwh_pkg::FIRST_FREE_CODE;
               width_ff <= minb;
            end else begin
               nfc_ff <= nfc_step;
               if (nfc_step > top && width_ff < maxb) begin
                  width_ff <= width_ff + lzwh_pkg::WIDTH_BITS'(1);
               end
            end
         end
         if (cmd.flush) begin
            prefix_ff       <= '0;
            prefix_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff   <= req_data.data_byte;
         pos_ff    <= rd_addr;
         probes_ff <= (AW+1)'(1);
      end
      if (cmd.probe_next) begin
         pos_ff    <= pos_inc;
         probes_ff <= probes_ff + (AW+1)'(1);
      end
      if (cmd.probe_miss) begin
         slot_free_ff <= !status.entry_valid;
      end
      if (cmd.miss_commit) begin
         rsp_ff <= '{out_code: prefix_ff, code_width: width_ff,
                     dict_was_reset: reset_due, last_code: 1'b0};
      end
      if (cmd.flush) begin
         rsp_ff <= '{out_code: prefix_ff, code_width: width_ff,
                     dict_was_reset: 1'b0, last_code: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.miss_commit || cmd.flush) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
   a_width_in_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= lzwh_pkg::WIDTH_FLOOR) && (width_ff <= lzwh_pkg::WIDTH_CEIL))
      else $error("code width out of range");
   a_next_code_bounded: assert property (@(posedge clock) disable iff (reset)
      nfc_ff <= 17'h10000)
      else $error("next free code beyond code space");
`endif

endmodule
`default_nettype wire

>>> rtl/lzw_hashed_encoder.sv
`default_nettype none
// A dictionary hit passes the accept and probe states before the next ready,
// plus a further probe for every extra slot on the linear probe chain; a miss
// adds the miss state and the code register; an end-of-stream flush adds the
// flush state. The single read port of the dictionary RAM sets the rate: one
// probe per cycle, one request at a time. Reset is synchronous; after reset,
// and every 255th clear, a wipe rewrites all HASH_SLOTS slots, requests held.
// -----------------------------------------------------------------------------
// lzw_hashed_encoder
// LZW encoder with hashed dictionary, variable code width and CSR port.
// -----------------------------------------------------------------------------
module lzw_hashed_encoder #(
   parameter int HASH_SLOTS = lzwh_pkg::HASH_SLOTS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire lzwh_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output lzwh_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lzwh_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [lzwh_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [lzwh_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   logic [4:0] min_bits_ff;
   logic [4:0] max_bits_ff;
   logic       early_ff;
   logic       csr_write;

   lzwh_pkg::cmd_type    cmd;
   lzwh_pkg::status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_bits_ff <= 5'd9;
         max_bits_ff <= 5'd16;
         early_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            lzwh_pkg::REG_MIN_CODE_BITS: min_bits_ff <= csr_pwdata[4:0];
            lzwh_pkg::REG_MAX_CODE_BITS: max_bits_ff <= csr_pwdata[4:0];
            lzwh_pkg::REG_EARLY_RESET:   early_ff    <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         lzwh_pkg::REG_MIN_CODE_BITS: csr_prdata = {27'd0, min_bits_ff};
         lzwh_pkg::REG_MAX_CODE_BITS: csr_prdata = {27'd0, max_bits_ff};
         lzwh_pkg::REG_EARLY_RESET:   csr_prdata = {31'd0, early_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   lzwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lzwh_datapath #(
      .HASH_SLOTS (HASH_SLOTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .min_code_bits (min_bits_ff),
      .max_code_bits (max_bits_ff),
      .early_reset   (early_ff)
   );

endmodule
`default_nettype wire

>>> tb/lzw_hashed_encoder_tb.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lzw_hashed_encoder_tb
// Drives byte streams into the hashed LZW encoder under several code-width
// and early-reset settings, predicts every emitted code with a model of its
// own, and checks the codes in order with random stalls on both sides.
// -----------------------------------------------------------------------------
module lzw_hashed_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 65536;
   localparam int QUIET_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lzwh_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lzwh_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [lzwh_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [lzwh_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [lzwh_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   always #1 clock = ~clock;

   lzw_hashed_encoder u_top (.*);

   // encoder model state
   logic [4:0]  cfg_min = 5'd9;
   logic [4:0]  cfg_max = 5'd16;
   logic        cfg_early = 1'b0;
   logic [15:0] cur_prefix = '0;
   logic        have_prefix = 1'b0;
   int unsigned next_code = 256;
   int unsigned cur_width = 9;
   int unsigned dict_gen = 1;
   int unsigned slot_gen [SLOTS];
   logic [39:0] slot_data [SLOTS];

   lzwh_pkg::req_type pending_bytes [$];
   lzwh_pkg::rsp_type expected_codes [$];
   int   errors = 0;
   bit   no_idle = 1'b0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   quiet_cycles = 0;

   function automatic int unsigned width_floor();
      return cfg_min < 9 ? 9 : (cfg_min > 16 ? 16 : cfg_min);
   endfunction

   function automatic int unsigned width_ceiling();
      int unsigned m;
      m = cfg_max > 16 ? 16 : cfg_max;
      return m < width_floor() ? width_floor() : m;
   endfunction

   function automatic void wipe_dictionary();
      dict_gen++;
      next_code = 256;
      cur_width = width_floor();
   endfunction

   function automatic void emit_code(logic [15:0] c, int unsigned w, bit rst, bit last);
      lzwh_pkg::rsp_type r;
      r.out_code = c;
      r.code_width = w[4:0];
      r.dict_was_reset = rst;
      r.last_code = last;
      expected_codes.push_back(r);
   endfunction

   function automatic void encode_byte(lzwh_pkg::req_type r);
      int unsigned pos, w, top;
      bit found;
      logic [15:0] hit_code;
      found = 1'b0;
      hit_code = '0;
      if (!have_prefix) begin
         wipe_dictionary();
         cur_prefix = {8'd0, r.data_byte};
         have_prefix = 1'b1;
      end else begin
         pos = ({cur_prefix, 8'd0} ^ r.data_byte) & 16'hFFFF;
         for (int n = 0; n < SLOTS; n++) begin
            if (slot_gen[pos] != dict_gen) break;
            if (slot_data[pos][39:24] == cur_prefix && slot_data[pos][23:16] == r.data_byte) begin
               found = 1'b1;
               hit_code = slot_data[pos][15:0];
               break;
            end
            pos = (pos + 1) % SLOTS;
         end
         if (found) begin
            cur_prefix = hit_code;
         end else begin
            w = cur_width;
            if (cfg_early && next_code >= (1 << width_ceiling()) - 1) begin
               wipe_dictionary();
               emit_code(cur_prefix, w, 1'b1, 1'b0);
            end else begin
               top = (1 << cur_width) - 1;
               if (next_code <= top) begin
                  pos = ({cur_prefix, 8'd0} ^ r.data_byte) & 16'hFFFF;
                  for (int n = 0; n < SLOTS; n++) begin
                     if (slot_gen[pos] != dict_gen) begin
                        slot_gen[pos] = dict_gen;
                        slot_data[pos] = {cur_prefix, r.data_byte, next_code[15:0]};
                        break;
                     end
                     pos = (pos + 1) % SLOTS;
                  end
                  next_code++;
               end
               if (next_code > top && cur_width < width_ceiling()) cur_width++;
               emit_code(cur_prefix, w, 1'b0, 1'b0);
            end
            cur_prefix = {8'd0, r.data_byte};
         end
      end
      if (r.end_of_stream) begin
         emit_code(cur_prefix, cur_width, 1'b0, 1'b1);
         have_prefix = 1'b0;
         cur_prefix = '0;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) encode_byte(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_data <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               if (!no_idle && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected code, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               lzwh_pkg::rsp_type e;
               e = expected_codes.pop_front();
               if (e.out_code !== rsp_data.out_code)
                  $display("%0t: out_code expected %0d actual %0d", $time, e.out_code,
                           rsp_data.out_code);
               if (e.code_width !== rsp_data.code_width)
                  $display("%0t: code_width expected %0d actual %0d", $time, e.code_width,
                           rsp_data.code_width);
               if (e.dict_was_reset !== rsp_data.dict_was_reset)
                  $display("%0t: dict_was_reset expected %0b actual %0b", $time,
                           e.dict_was_reset, rsp_data.dict_was_reset);
               if (e.last_code !== rsp_data.last_code)
                  $display("%0t: last_code expected %0b actual %0b", $time, e.last_code,
                           rsp_data.last_code);
               if (e !== rsp_data) errors++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            recv_gap <= $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: counts cycles with no request or code moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [4:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(logic [4:0] mn, logic [4:0] mx, logic er);
      csr_write(lzwh_pkg::REG_MIN_CODE_BITS, mn);
      csr_write(lzwh_pkg::REG_MAX_CODE_BITS, mx);
      csr_write(lzwh_pkg::REG_EARLY_RESET, {4'd0, er});
      cfg_min = mn;
      cfg_max = mx;
      cfg_early = er;
   endtask

   task automatic add_byte(logic [7:0] b, logic eos);
      lzwh_pkg::req_type r;
      r.data_byte = b;
      r.end_of_stream = eos;
      pending_bytes.push_back(r);
   endtask

   // random stream: a small alphabet most of the time so that prefixes grow
   task automatic add_stream(int len);
      logic [7:0] alpha [4];
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++)
         add_byte(wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)],
                  i == len - 1);
   endtask

   task automatic run_random(int budget);
      int len;
      while (budget > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(280, 420) : $urandom_range(1, 60);
         add_stream(len);
         budget -= len;
      end
   endtask

   // hold until every request went out and every code came back
   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || send_gap > 0 ||
             expected_codes.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: single-byte streams, byte extremes, repeats, alternations
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      repeat (6) add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b1);
      repeat (4) add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      repeat (3) begin
         add_byte(8'hAA, 1'b0);
         add_byte(8'h55, 1'b0);
      end
      add_byte(8'hAA, 1'b1);
      run_random(120);
      drain();

      configure(5'd16, 5'd9, 1'b0);
      run_random(100);
      drain();

      configure(5'd9, 5'd9, 1'b1);
      run_random(150);
      drain();

      configure(5'd0, 5'd31, 1'b1);
      run_random(100);
      drain();

      configure(5'd9, 5'd9, 1'b0);
      add_stream(420);
      run_random(30);
      drain();

      no_idle = 1'b1;
      configure(5'd10, 5'd12, 1'b0);
      run_random(60);
      drain();

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
rtl/lzwh_pkg.sv
rtl/lzwh_ram.sv
rtl/lzwh_ctrl.sv
rtl/lzwh_datapath.sv
rtl/lzw_hashed_encoder.sv
tb/lzw_hashed_encoder_tb.sv
